/* rtl/core/bda_pkg.sv */
// ---------------------------------------------------------------------------
// bda_pkg
// Shared types, codes and widths for the banker's deadlock avoidance core.
// ---------------------------------------------------------------------------
package bda_pkg;

  localparam int DEF_CUSTOMERS      = 5;
  localparam int DEF_RESOURCE_TYPES = 4;

  localparam int HELD_W      = 4;   // one allocation or claim entry
  localparam int TOTAL_W     = 8;   // one configured total
  localparam int SUM_W       = 8;   // column sum of allocations, at most 5 x 15 at the default size
  localparam int WORK_W      = 9;   // signed lane: available, need, work
  localparam int CARRIED_RES = 4;   // resources that carry totals, claims, amounts
  localparam int CLAIM_ROWS  = 5;   // customers that carry claim registers
  localparam int CLAIM_W     = 16;
  localparam int SLOT_W      = 3;
  localparam int OUT_SLOTS   = 5;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = 3;

  localparam logic [CFG_IDX_W-1:0] REG_TOTALS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLAIM_FIRST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLAIM_LAST  = 3'd5;

  typedef enum logic [1:0] {
    OP_REQUEST = 2'd0,
    OP_RELEASE = 2'd1,
    OP_RUN     = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_NO_AVAIL  = 3'd1,
    STAT_OVER_NEED = 3'd2,
    STAT_UNSAFE    = 3'd3,
    STAT_OVER_HELD = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHK_AVAIL,
    S_CHK_NEED,
    S_REL_CHECK,
    S_APPLY,
    S_SCAN_INIT,
    S_SCAN,
    S_ROLLBACK
  } state_t;

  typedef logic signed [WORK_W-1:0] lane_t;

  function automatic lane_t from_nib(logic [HELD_W-1:0] v);
    return lane_t'({{(WORK_W-HELD_W){1'b0}}, v});
  endfunction

  function automatic lane_t from_byte(logic [TOTAL_W-1:0] v);
    return lane_t'({{(WORK_W-TOTAL_W){1'b0}}, v});
  endfunction

endpackage

/* rtl/core/bda_row_unit.sv */
// ---------------------------------------------------------------------------
// bda_row_unit
// Shared row unit: signed lane compare a > b and lane add b + c.
// ---------------------------------------------------------------------------
module bda_row_unit import bda_pkg::*; #(
  parameter int LANES = DEF_RESOURCE_TYPES
) (
  input  lane_t             a   [LANES],
  input  lane_t             b   [LANES],
  input  lane_t             c   [LANES],
  output logic [LANES-1:0]  gt,
  output lane_t             sum [LANES]
);

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      gt[i]  = a[i] > b[i];
      sum[i] = b[i] + c[i];
    end
  end

endmodule

/* rtl/core/bankers_deadlock_avoidance_core.sv */
// ---------------------------------------------------------------------------
// bankers_deadlock_avoidance_core
// Banker's algorithm safety checker. Pulse start with op, customer and four
// amounts while busy is low; the beat is taken at that edge and busy rises
// for a request or release of an in-range customer. Exactly one result beat
// follows, shown for one cycle with done high; the receiver cannot stall it,
// so capture status and the five safe-order slots on that cycle. Run, no-op
// and out-of-range customers answer in the cycle after the start beat. Busy
// covers check available, check need, apply, scan init and scan for a grant,
// plus rollback if undone, and ends after check need on a failed request; a
// release takes release check, apply, scan init and scan, or ends after
// release check if it exceeds the allocation. One shared row unit checks one
// customer's need against the work vector per cycle; the scan makes at most
// CUSTOMERS squared visits, 25 or less at the default size. The done beat
// shows on the cycle right after busy falls, and the next start is taken on
// that same cycle. Configuration writes go through cfg_write / cfg_index /
// cfg_data and must only be issued while busy is low.
// ---------------------------------------------------------------------------
module bankers_deadlock_avoidance_core import bda_pkg::*; #(
  parameter int CUSTOMERS      = DEF_CUSTOMERS,
  parameter int RESOURCE_TYPES = DEF_RESOURCE_TYPES
) (
  input  logic                  clk,
  input  logic                  rst,
  // command side
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            op,
  input  logic [2:0]            customer,
  input  logic [3:0]            amount_a,
  input  logic [3:0]            amount_b,
  input  logic [3:0]            amount_c,
  input  logic [3:0]            amount_d,
  // result side
  output logic                  done,
  output logic [2:0]            status,
  output logic [2:0]            first_customer,
  output logic [2:0]            second_customer,
  output logic [2:0]            third_customer,
  output logic [2:0]            fourth_customer,
  output logic [2:0]            fifth_customer,
  // configuration
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CUST_W = $clog2(CUSTOMERS);
  localparam int CNT_W  = $clog2(CUSTOMERS + 1);
  localparam logic [4:0]        CUST_LIM  = 5'(CUSTOMERS);
  localparam logic [CUST_W-1:0] LAST_CUST = CUST_W'(CUSTOMERS - 1);
  localparam logic [CNT_W-1:0]  ALL_DONE  = CNT_W'(CUSTOMERS);

  // sequencer
  state_t state, state_next;

  // configuration registers
  logic [TOTAL_W*CARRIED_RES-1:0] totals;
  logic [CLAIM_W-1:0]             max_claim [CLAIM_ROWS];

  // allocation matrix, per-resource column sums and the reported safe order
  logic [HELD_W-1:0] held       [CUSTOMERS][RESOURCE_TYPES];
  logic [SUM_W-1:0]  sums       [RESOURCE_TYPES];
  logic [SLOT_W-1:0] safe_order [CUSTOMERS];

  // latched command
  op_t               op_q;
  logic [CUST_W-1:0] cust_q;
  logic [HELD_W-1:0] amt_q [RESOURCE_TYPES];

  // scan working state
  lane_t                     work [RESOURCE_TYPES];
  logic [SLOT_W-1:0]         seq  [CUSTOMERS];
  logic [CUSTOMERS-1:0]      done_mask;
  logic [CUST_W-1:0]         idx;
  logic [CNT_W-1:0]          count;
  logic                      progress;
  logic [RESOURCE_TYPES-1:0] fail_avail;

  // combinational
  logic              accept;
  logic              cust_out;
  logic [HELD_W-1:0] amt_in    [RESOURCE_TYPES];
  lane_t             total_r   [RESOURCE_TYPES];
  lane_t             avail     [RESOURCE_TYPES];
  logic [CUST_W-1:0] row_sel;
  logic              row_claimed;
  logic [2:0]        claim_idx;
  logic [HELD_W-1:0] held_row  [RESOURCE_TYPES];
  logic [HELD_W-1:0] claim_row [RESOURCE_TYPES];
  lane_t             need_row  [RESOURCE_TYPES];
  lane_t             amt_x     [RESOURCE_TYPES];
  lane_t             amt_neg   [RESOURCE_TYPES];
  lane_t             held_x    [RESOURCE_TYPES];

  lane_t                     ua   [RESOURCE_TYPES];
  lane_t                     ub   [RESOURCE_TYPES];
  lane_t                     uc   [RESOURCE_TYPES];
  logic [RESOURCE_TYPES-1:0] ugt;
  lane_t                     usum [RESOURCE_TYPES];

  logic              finish;
  status_t           fin_status;
  logic              need_fail;
  logic              first_is_avail;
  logic              fits_now;
  logic [CNT_W-1:0]  count_n;
  logic              prog_n;
  logic              scan_safe;
  logic              scan_dead;
  logic [SLOT_W-1:0] seq_next [CUSTOMERS];
  logic [SLOT_W-1:0] out_slot [OUT_SLOTS];
  logic              sums_ok;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign cust_out = ({2'b00, customer} >= CUST_LIM);

  // scan walks the customers, everything else works on the latched customer
  assign row_sel     = (state == S_SCAN) ? idx : cust_q;
  assign row_claimed = (int'(row_sel) < CLAIM_ROWS);
  assign claim_idx   = row_claimed ? 3'(row_sel) : 3'd0;

  // per-resource lanes; resources past the four carried read as zero
  for (genvar J = 0; J < RESOURCE_TYPES; J++) begin : g_res
    if (J == 0) begin : g_a
      assign amt_in[J] = amount_a;
    end else if (J == 1) begin : g_b
      assign amt_in[J] = amount_b;
    end else if (J == 2) begin : g_c
      assign amt_in[J] = amount_c;
    end else if (J == 3) begin : g_d
      assign amt_in[J] = amount_d;
    end else begin : g_none
      assign amt_in[J] = '0;
    end

    if (J < CARRIED_RES) begin : g_cfg
      assign total_r[J]   = from_byte(totals[TOTAL_W*J +: TOTAL_W]);
      assign claim_row[J] = row_claimed ? max_claim[claim_idx][HELD_W*J +: HELD_W] : '0;
    end else begin : g_nocfg
      assign total_r[J]   = '0;
      assign claim_row[J] = '0;
    end

    assign held_row[J] = held[row_sel][J];
    assign held_x[J]   = from_nib(held_row[J]);
    assign amt_x[J]    = from_nib(amt_q[J]);
    assign amt_neg[J]  = -amt_x[J];
    assign need_row[J] = from_nib(claim_row[J]) - held_x[J];
    assign avail[J]    = total_r[J] - from_byte(sums[J]);
  end

  bda_row_unit #(
    .LANES (RESOURCE_TYPES)
  ) u_row (
    .a   (ua),
    .b   (ub),
    .c   (uc),
    .gt  (ugt),
    .sum (usum)
  );

  // request check: lowest failing resource decides, available before need
  always_comb begin
    logic found;
    found          = 1'b0;
    first_is_avail = 1'b0;
    for (int j = 0; j < RESOURCE_TYPES; j++) begin
      if (!found && (ugt[j] || fail_avail[j])) begin
        found          = 1'b1;
        first_is_avail = fail_avail[j];
      end
    end
  end

  assign need_fail = |(ugt | fail_avail);

  // one scan visit: skip finished customers, else need <= work on every lane
  assign fits_now  = !done_mask[idx] && !(|ugt);
  assign count_n   = count + CNT_W'(fits_now);
  assign prog_n    = progress || fits_now;
  assign scan_safe = (count_n == ALL_DONE);
  assign scan_dead = (idx == LAST_CUST) && !prog_n;

  always_comb begin
    seq_next = seq;
    if (fits_now) begin
      seq_next[count[CUST_W-1:0]] = SLOT_W'(idx);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && !cust_out) begin
          if (op_t'(op) == OP_REQUEST) begin
            state_next = S_CHK_AVAIL;
          end else if (op_t'(op) == OP_RELEASE) begin
            state_next = S_REL_CHECK;
          end
        end
      end
      S_CHK_AVAIL: state_next = S_CHK_NEED;
      S_CHK_NEED:  state_next = need_fail ? S_IDLE : S_APPLY;
      S_REL_CHECK: state_next = (|ugt) ? S_IDLE : S_APPLY;
      S_APPLY:     state_next = S_SCAN_INIT;
      S_SCAN_INIT: state_next = S_SCAN;
      S_SCAN: begin
        if (scan_safe) begin
          state_next = S_IDLE;
        end else if (scan_dead) begin
          state_next = (op_q == OP_REQUEST) ? S_ROLLBACK : S_IDLE;
        end
      end
      S_ROLLBACK:  state_next = S_IDLE;
    endcase
  end

  // row unit operands and result beat
  always_comb begin
    ua         = '{default: '0};
    ub         = '{default: '0};
    uc         = '{default: '0};
    finish     = 1'b0;
    fin_status = STAT_OK;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (op_t'(op))
            OP_REQUEST: begin
              finish     = cust_out;
              fin_status = STAT_OVER_NEED;
            end
            OP_RELEASE: begin
              finish     = cust_out;
              fin_status = STAT_OVER_HELD;
            end
            OP_RUN, OP_NOP: begin
              finish     = 1'b1;
              fin_status = STAT_OK;
            end
          endcase
        end
      end
      S_CHK_AVAIL: begin
        ua = amt_x;
        ub = avail;
      end
      S_CHK_NEED: begin
        ua         = amt_x;
        ub         = need_row;
        finish     = need_fail;
        fin_status = first_is_avail ? STAT_NO_AVAIL : STAT_OVER_NEED;
      end
      S_REL_CHECK: begin
        ua         = amt_x;
        ub         = held_x;
        finish     = |ugt;
        fin_status = STAT_OVER_HELD;
      end
      S_APPLY: begin
        ub = held_x;
        uc = (op_q == OP_REQUEST) ? amt_x : amt_neg;
      end
      S_SCAN_INIT: begin
        finish = 1'b0;
      end
      S_SCAN: begin
        ua         = need_row;
        ub         = work;
        uc         = held_x;
        finish     = scan_safe || (scan_dead && (op_q != OP_REQUEST));
        fin_status = STAT_OK;
      end
      S_ROLLBACK: begin
        ub         = held_x;
        uc         = amt_neg;
        finish     = 1'b1;
        fin_status = STAT_UNSAFE;
      end
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      status     <= '0;
      totals     <= '0;
      max_claim  <= '{default: '0};
      held       <= '{default: '{default: '0}};
      sums       <= '{default: '0};
      safe_order <= '{default: '0};
    end else begin
      state <= state_next;
      done  <= finish;
      if (finish) begin
        status <= fin_status;
      end

      if (cfg_write) begin
        if (cfg_index == REG_TOTALS) begin
          totals <= cfg_data[TOTAL_W*CARRIED_RES-1:0];
        end else if (cfg_index >= REG_CLAIM_FIRST && cfg_index <= REG_CLAIM_LAST) begin
          max_claim[3'(cfg_index - REG_CLAIM_FIRST)] <= cfg_data[CLAIM_W-1:0];
        end
      end

      // run hands every unit back
      if (accept && op_t'(op) == OP_RUN) begin
        held <= '{default: '{default: '0}};
        sums <= '{default: '0};
      end

      // grant, release or rollback of the latched customer's row
      if (state == S_APPLY || state == S_ROLLBACK) begin
        for (int j = 0; j < RESOURCE_TYPES; j++) begin
          held[cust_q][j] <= usum[j][HELD_W-1:0];
          if (state == S_APPLY && op_q == OP_REQUEST) begin
            sums[j] <= sums[j] + SUM_W'(amt_q[j]);
          end else begin
            sums[j] <= sums[j] - SUM_W'(amt_q[j]);
          end
        end
      end

      if (state == S_SCAN && scan_safe) begin
        safe_order <= seq_next;
      end
    end
  end

  // command latch and scan datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= op_t'(op);
      cust_q <= CUST_W'(customer);
      amt_q  <= amt_in;
    end

    if (state == S_CHK_AVAIL) begin
      fail_avail <= ugt;
    end

    if (state == S_SCAN_INIT) begin
      work      <= avail;
      done_mask <= '0;
      count     <= '0;
      idx       <= '0;
      progress  <= 1'b0;
    end

    if (state == S_SCAN) begin
      seq   <= seq_next;
      count <= count_n;
      if (fits_now) begin
        work           <= usum;
        done_mask[idx] <= 1'b1;
      end
      // a new pass starts with no progress recorded
      if (idx == LAST_CUST) begin
        idx      <= '0;
        progress <= 1'b0;
      end else begin
        idx      <= idx + CUST_W'(1);
        progress <= prog_n;
      end
    end
  end

  // safe order slots, positions past the customer count read zero
  for (genvar K = 0; K < OUT_SLOTS; K++) begin : g_slot
    if (K < CUSTOMERS) begin : g_used
      assign out_slot[K] = safe_order[K];
    end else begin : g_unused
      assign out_slot[K] = '0;
    end
  end

  assign first_customer  = out_slot[0];
  assign second_customer = out_slot[1];
  assign third_customer  = out_slot[2];
  assign fourth_customer = out_slot[3];
  assign fifth_customer  = out_slot[4];

  // column sums must track the allocation matrix
  always_comb begin
    logic [SUM_W-1:0] col;
    sums_ok = 1'b1;
    for (int j = 0; j < RESOURCE_TYPES; j++) begin
      col = '0;
      for (int c = 0; c < CUSTOMERS; c++) begin
        col = col + SUM_W'(held[c][j]);
      end
      if (col != sums[j]) begin
        sums_ok = 1'b0;
      end
    end
  end

  a_sums_track: assert property (@(posedge clk) disable iff (rst) sums_ok)
    else $error("column sums out of step with allocations");

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> (state == S_IDLE))
    else $error("result beat while sequencer busy");

  a_busy_start: assert property (@(posedge clk) disable iff (rst) $rose(busy) |-> $past(start))
    else $error("sequencer left idle without a start beat");

  a_scan_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (count < ALL_DONE))
    else $error("scan ran past the last customer");

  a_scan_mask: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> ($countones(done_mask) == int'(count)))
    else $error("finished mask disagrees with safe sequence length");

endmodule

/* verif/bda_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bda_checker
// Watches the command, result and register ports of the banker's core, keeps
// its own allocation matrix and safe order, predicts each answer when a
// command beat is taken and compares every result beat with the oldest one.
// ---------------------------------------------------------------------------
module bda_checker import bda_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  logic [1:0]            op,
  input  logic [2:0]            customer,
  input  logic [3:0]            amount_a,
  input  logic [3:0]            amount_b,
  input  logic [3:0]            amount_c,
  input  logic [3:0]            amount_d,
  input  logic                  done,
  input  logic [2:0]            status,
  input  logic [2:0]            first_customer,
  input  logic [2:0]            second_customer,
  input  logic [2:0]            third_customer,
  input  logic [2:0]            fourth_customer,
  input  logic [2:0]            fifth_customer,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending_count
);

  localparam int NC = DEF_CUSTOMERS;
  localparam int NR = DEF_RESOURCE_TYPES;

  typedef struct packed {
    status_t                          st;
    logic [OUT_SLOTS-1:0][SLOT_W-1:0] slot;
  } answer_t;

  logic [CFG_DATA_W-1:0]   totals_q;
  logic [CLAIM_W-1:0]      claim_q [CLAIM_ROWS];
  logic [HELD_W-1:0]       held_q  [NC][NR];
  logic [SLOT_W-1:0]       order_q [NC];
  answer_t                 answer_q [$];
  int                      errors  = 0;
  int                      waiting = 0;

  assign fail_count    = errors;
  assign pending_count = waiting;

  function automatic int free_units(int j);
    int s;
    s = (j < CARRIED_RES) ? int'(totals_q[TOTAL_W*j +: TOTAL_W]) : 0;
    for (int c = 0; c < NC; c++) s = s - int'(held_q[c][j]);
    return s;
  endfunction

  function automatic int need_units(int c, int j);
    int cl;
    cl = (c < CLAIM_ROWS && j < CARRIED_RES) ? int'(claim_q[c][HELD_W*j +: HELD_W]) : 0;
    return cl - int'(held_q[c][j]);
  endfunction

  // passes in index order until all finish or a pass makes no progress
  function automatic bit find_safe_order();
    int               work [NR];
    bit               fin  [NC];
    logic [SLOT_W-1:0] seq [NC];
    int               count;
    bit               moved;
    bit               fits;
    count = 0;
    moved = 1'b1;
    for (int j = 0; j < NR; j++) work[j] = free_units(j);
    for (int i = 0; i < NC; i++) begin
      fin[i] = 1'b0;
      seq[i] = '0;
    end
    while (count < NC && moved) begin
      moved = 1'b0;
      for (int i = 0; i < NC; i++) begin
        if (!fin[i]) begin
          fits = 1'b1;
          for (int j = 0; j < NR; j++)
            if (need_units(i, j) > work[j]) fits = 1'b0;
          if (fits) begin
            for (int j = 0; j < NR; j++) work[j] = work[j] + int'(held_q[i][j]);
            fin[i]     = 1'b1;
            seq[count] = SLOT_W'(i);
            count++;
            moved      = 1'b1;
          end
        end
      end
    end
    if (count < NC) return 1'b0;
    for (int i = 0; i < NC; i++) order_q[i] = seq[i];
    return 1'b1;
  endfunction

  // applies one command to the shadow state and forms its answer
  function automatic answer_t settle_command(op_t o, logic [2:0] c, logic [15:0] amts);
    answer_t ans;
    status_t st;
    int      ci;
    int      a;
    st = STAT_OK;
    ci = int'(c);
    case (o)
      OP_REQUEST: begin
        if (ci >= NC) begin
          st = STAT_OVER_NEED;
        end else begin
          // first failing resource decides, available before need
          for (int j = 0; j < NR; j++) begin
            a = (j < CARRIED_RES) ? int'(amts[HELD_W*j +: HELD_W]) : 0;
            if (st == STAT_OK) begin
              if (a > free_units(j)) st = STAT_NO_AVAIL;
              else if (a > need_units(ci, j)) st = STAT_OVER_NEED;
            end
          end
          if (st == STAT_OK) begin
            for (int j = 0; j < NR; j++)
              held_q[ci][j] = held_q[ci][j] + amts[HELD_W*j +: HELD_W];
            if (!find_safe_order()) begin
              // unsafe: take the grant back
              for (int j = 0; j < NR; j++)
                held_q[ci][j] = held_q[ci][j] - amts[HELD_W*j +: HELD_W];
              st = STAT_UNSAFE;
            end
          end
        end
      end
      OP_RELEASE: begin
        if (ci >= NC) begin
          st = STAT_OVER_HELD;
        end else begin
          for (int j = 0; j < NR; j++)
            if (amts[HELD_W*j +: HELD_W] > held_q[ci][j]) st = STAT_OVER_HELD;
          if (st == STAT_OK) begin
            for (int j = 0; j < NR; j++)
              held_q[ci][j] = held_q[ci][j] - amts[HELD_W*j +: HELD_W];
            void'(find_safe_order());
          end
        end
      end
      OP_RUN: begin
        for (int i = 0; i < NC; i++)
          for (int j = 0; j < NR; j++) held_q[i][j] = '0;
      end
      default: ;
    endcase
    ans.st = st;
    for (int k = 0; k < OUT_SLOTS; k++) ans.slot[k] = (k < NC) ? order_q[k] : '0;
    return ans;
  endfunction

  task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
    errors++;
    if (errors <= 10)
      $display("mismatch at %0t on %s: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  always @(posedge clk) begin
    answer_t                          exp;
    logic [OUT_SLOTS-1:0][SLOT_W-1:0] got;
    if (rst) begin
      totals_q = '0;
      for (int i = 0; i < CLAIM_ROWS; i++) claim_q[i] = '0;
      for (int i = 0; i < NC; i++) begin
        order_q[i] = '0;
        for (int j = 0; j < NR; j++) held_q[i][j] = '0;
      end
      answer_q.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_TOTALS)
          totals_q = cfg_data;
        else if (cfg_index >= REG_CLAIM_FIRST && cfg_index <= REG_CLAIM_LAST)
          claim_q[cfg_index - REG_CLAIM_FIRST] = cfg_data[CLAIM_W-1:0];
      end
      if (done) begin
        if (answer_q.size() == 0) begin
          report("result beat with nothing expected", '0, {29'd0, status});
        end else begin
          exp = answer_q.pop_front();
          got = {fifth_customer, fourth_customer, third_customer, second_customer,
                 first_customer};
          if (exp.st !== status) report("status", {29'd0, exp.st}, {29'd0, status});
          for (int k = 0; k < OUT_SLOTS; k++)
            if (exp.slot[k] !== got[k])
              report($sformatf("safe order slot %0d", k), {29'd0, exp.slot[k]},
                     {29'd0, got[k]});
        end
      end
      if (start && !busy)
        answer_q.push_back(settle_command(op_t'(op), customer,
                                          {amount_d, amount_c, amount_b, amount_a}));
    end
    waiting = answer_q.size();
  end

endmodule

/* verif/bankers_deadlock_avoidance_core_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bankers_deadlock_avoidance_core_tb
// Drives request, release, run and no-op commands into the banker's core
// under a series of total and claim settings, directed corner cases first and
// then random traffic with random sender gaps; the checker predicts and
// compares every result beat and hands back its failure count.
// ---------------------------------------------------------------------------
module bankers_deadlock_avoidance_core_tb;
  import bda_pkg::*;

  localparam int RUN_ITEMS    = 550;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 40;
  // indexes past the last claim register, decoded as nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = REG_CLAIM_LAST + 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = REG_CLAIM_LAST + 3'd2;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic [1:0]            op;
  logic [2:0]            customer;
  logic [3:0]            amount_a;
  logic [3:0]            amount_b;
  logic [3:0]            amount_c;
  logic [3:0]            amount_d;
  logic                  done;
  logic [2:0]            status;
  logic [2:0]            first_customer;
  logic [2:0]            second_customer;
  logic [2:0]            third_customer;
  logic [2:0]            fourth_customer;
  logic [2:0]            fifth_customer;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int                    fail_count;
  int                    pending_count;
  int                    cycle_count = 0;
  int                    sent = 0;
  bit                    quiet = 1'b0;   // no sender gaps in this stretch

  // settings staged for a full register load
  logic [CFG_DATA_W-1:0] totals_set;
  logic [CLAIM_W-1:0]    claim_set [CLAIM_ROWS];

  bankers_deadlock_avoidance_core dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .op              (op),
    .customer        (customer),
    .amount_a        (amount_a),
    .amount_b        (amount_b),
    .amount_c        (amount_c),
    .amount_d        (amount_d),
    .done            (done),
    .status          (status),
    .first_customer  (first_customer),
    .second_customer (second_customer),
    .third_customer  (third_customer),
    .fourth_customer (fourth_customer),
    .fifth_customer  (fifth_customer),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  bda_checker chk (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .op              (op),
    .customer        (customer),
    .amount_a        (amount_a),
    .amount_b        (amount_b),
    .amount_c        (amount_c),
    .amount_d        (amount_d),
    .done            (done),
    .status          (status),
    .first_customer  (first_customer),
    .second_customer (second_customer),
    .third_customer  (third_customer),
    .fourth_customer (fourth_customer),
    .fifth_customer  (fifth_customer),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending_count   (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog: a hung handshake or a missing result beat ends here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // one command beat; start stays high into the next beat when no gap follows
  task automatic send_cmd(input op_t o, input logic [2:0] c, input logic [3:0] a0,
                          input logic [3:0] a1, input logic [3:0] a2, input logic [3:0] a3);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    start    <= 1'b1;
    op       <= o;
    customer <= c;
    amount_a <= a0;
    amount_b <= a1;
    amount_c <= a2;
    amount_d <= a3;
    // busy read here is its value before the edge, so this edge took the beat
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drop start and wait until every expected result beat has come back
  task automatic go_idle();
    start <= 1'b0;
    @(negedge clk);
    while (pending_count != 0 || busy) @(negedge clk);
    @(posedge clk);
  endtask

  // leaves cfg_write high; the caller lowers it after the last write
  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic load_all();
    put_reg(REG_TOTALS, totals_set);
    for (int i = 0; i < CLAIM_ROWS; i++)
      put_reg(REG_CLAIM_FIRST + CFG_IDX_W'(i), {16'd0, claim_set[i]});
    cfg_write <= 1'b0;
  endtask

  // mostly small amounts so grants pile up, now and then anything
  function automatic logic [3:0] pick_amount();
    return ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 2));
  endfunction

  task automatic random_cmd();
    int         r;
    logic [2:0] c;
    r = $urandom_range(0, 99);
    c = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
    if (r < 55)
      send_cmd(OP_REQUEST, c, pick_amount(), pick_amount(), pick_amount(), pick_amount());
    else if (r < 85)
      send_cmd(OP_RELEASE, c, pick_amount(), pick_amount(), pick_amount(), pick_amount());
    else if (r < 91)
      send_cmd(OP_RUN, 3'($urandom), 4'($urandom), 4'($urandom), 4'($urandom), 4'($urandom));
    else if (r < 95)
      send_cmd(OP_NOP, 3'($urandom), 4'($urandom), 4'($urandom), 4'($urandom), 4'($urandom));
    else
      send_cmd(OP_REQUEST, 3'($urandom), 4'($urandom), 4'($urandom), 4'($urandom),
               4'($urandom));
  endtask

  initial begin
    int kind;
    int n;
    start     <= 1'b0;
    op        <= OP_NOP;
    customer  <= '0;
    amount_a  <= '0;
    amount_b  <= '0;
    amount_c  <= '0;
    amount_d  <= '0;
    cfg_write <= 1'b0;
    cfg_index <= REG_TOTALS;
    cfg_data  <= '0;
    rst       <= 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed: a textbook-like setting, totals 10/5/7/6
    totals_set   = {8'd6, 8'd7, 8'd5, 8'd10};
    claim_set[0] = {4'd2, 4'd3, 4'd5, 4'd7};
    claim_set[1] = {4'd1, 4'd2, 4'd2, 4'd3};
    claim_set[2] = {4'd3, 4'd2, 4'd0, 4'd9};
    claim_set[3] = {4'd2, 4'd2, 4'd2, 4'd2};
    claim_set[4] = {4'd4, 4'd3, 4'd3, 4'd4};
    load_all();
    send_cmd(OP_REQUEST, 3'd0, 4'd0, 4'd1, 4'd0, 4'd0);
    send_cmd(OP_REQUEST, 3'd1, 4'd2, 4'd0, 4'd0, 4'd0);
    send_cmd(OP_REQUEST, 3'd2, 4'd3, 4'd0, 4'd2, 4'd0);
    send_cmd(OP_REQUEST, 3'd3, 4'd2, 4'd1, 4'd1, 4'd1);
    send_cmd(OP_REQUEST, 3'd4, 4'd0, 4'd0, 4'd2, 4'd2);
    // beyond available, beyond need, and a grant that leaves no safe order
    send_cmd(OP_REQUEST, 3'd0, 4'd15, 4'd15, 4'd15, 4'd15);
    send_cmd(OP_REQUEST, 3'd3, 4'd0, 4'd0, 4'd0, 4'd2);
    send_cmd(OP_REQUEST, 3'd4, 4'd3, 4'd3, 4'd1, 4'd2);
    // release over the allocation, then a good one
    send_cmd(OP_RELEASE, 3'd0, 4'd9, 4'd0, 4'd0, 4'd0);
    send_cmd(OP_RELEASE, 3'd1, 4'd1, 4'd0, 4'd0, 4'd0);
    // customers out of range
    send_cmd(OP_REQUEST, 3'd5, 4'd0, 4'd0, 4'd0, 4'd0);
    send_cmd(OP_REQUEST, 3'd7, 4'd1, 4'd1, 4'd1, 4'd1);
    send_cmd(OP_RELEASE, 3'd6, 4'd0, 4'd0, 4'd0, 4'd0);
    send_cmd(OP_NOP, 3'd7, 4'd15, 4'd15, 4'd15, 4'd15);
    send_cmd(OP_REQUEST, 3'd2, 4'd0, 4'd0, 4'd0, 4'd0);
    send_cmd(OP_RUN, 3'd0, 4'd0, 4'd0, 4'd0, 4'd0);

    // ---- directed: largest totals and claims
    go_idle();
    totals_set = '1;
    for (int i = 0; i < CLAIM_ROWS; i++) claim_set[i] = '1;
    load_all();
    send_cmd(OP_REQUEST, 3'd0, 4'd15, 4'd15, 4'd15, 4'd15);
    send_cmd(OP_REQUEST, 3'd4, 4'd15, 4'd15, 4'd15, 4'd15);
    send_cmd(OP_RELEASE, 3'd0, 4'd15, 4'd15, 4'd15, 4'd15);

    // ---- directed: totals pulled under what is held, so available goes negative
    go_idle();
    put_reg(REG_TOTALS, '0);
    cfg_write <= 1'b0;
    send_cmd(OP_REQUEST, 3'd2, 4'd0, 4'd0, 4'd0, 4'd0);
    // claims pulled under the allocation, so need goes negative
    go_idle();
    put_reg(REG_TOTALS, '1);
    put_reg(REG_CLAIM_LAST, '0);
    put_reg(REG_SPARE_LO, '1);
    put_reg(REG_SPARE_HI, '1);
    cfg_write <= 1'b0;
    send_cmd(OP_REQUEST, 3'd4, 4'd0, 4'd0, 4'd0, 4'd1);
    send_cmd(OP_RELEASE, 3'd4, 4'd1, 4'd1, 4'd1, 4'd1);
    send_cmd(OP_RUN, 3'd7, 4'd15, 4'd15, 4'd15, 4'd15);

    // ---- random phases, each under a fresh or partly changed setting
    while (sent < RUN_ITEMS) begin
      go_idle();
      kind = $urandom_range(0, 9);
      if (kind <= 4) begin
        // moderate totals against claims of 0..9, the usual banking case
        for (int j = 0; j < CARRIED_RES; j++)
          totals_set[TOTAL_W*j +: TOTAL_W] = 8'($urandom_range(0, 20));
        for (int i = 0; i < CLAIM_ROWS; i++)
          for (int j = 0; j < CARRIED_RES; j++)
            claim_set[i][HELD_W*j +: HELD_W] = 4'($urandom_range(0, 9));
        load_all();
      end else if (kind == 5) begin
        // all-zero or all-ones extremes
        totals_set = $urandom_range(0, 1) ? '1 : '0;
        for (int i = 0; i < CLAIM_ROWS; i++)
          claim_set[i] = $urandom_range(0, 1) ? '1 : '0;
        load_all();
      end else if (kind == 6) begin
        totals_set = $urandom;
        for (int i = 0; i < CLAIM_ROWS; i++) claim_set[i] = 16'($urandom);
        load_all();
      end else if (kind == 7) begin
        // one register changed under live allocations
        put_reg(CFG_IDX_W'($urandom_range(0, 5)), $urandom);
        cfg_write <= 1'b0;
      end else if (kind == 8) begin
        put_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
        cfg_write <= 1'b0;
      end
      quiet = ($urandom_range(0, 3) == 0);
      n = $urandom_range(15, 50);
      repeat (n) random_cmd();
    end

    go_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/bda_pkg.sv
rtl/core/bda_row_unit.sv
rtl/core/bankers_deadlock_avoidance_core.sv
verif/bda_checker.sv
verif/bankers_deadlock_avoidance_core_tb.sv
